@@ hw/rtl/ascii_decimal_number_parser_unit_assert.svh @@
// Assertion macros shared by the parser unit.
`ifndef ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH
`define ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH

// Condition that must hold on every clock edge outside reset.
`define ADNP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the same cycle as the trigger.
`define ADNP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/adnp_pkg.sv @@
package adnp_pkg;

    // Width of the signed mantissa and of the magnitude accumulator.
    localparam int VALUE_W = 32;
    localparam int PROD_W  = VALUE_W + 4;
    localparam int FRAC_W  = 4;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    // Parser phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_POINT = 3'd3;
    localparam logic [2:0] PH_FRAC  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SIGN    = 3'd1;
    localparam logic [2:0] ST_POINT   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_OVF     = 3'd4;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

    // Output queue depth.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]         frac_digits;
        logic [2:0]                status;
        logic                      last;
    } result_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
        logic [FRAC_W-1:0]  frac_count;
        logic               overflowed;
    } parse_state_t;

    // Results of one processed word, handed to the output queue.
    typedef struct packed {
        logic       push;
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    localparam parse_state_t CLEAR_STATE = '{
        phase:      PH_IDLE,
        negative:   1'b0,
        magnitude:  '0,
        frac_count: '0,
        overflowed: 1'b0
    };

    // Error result: zero value and digit count.
    function automatic result_t err_result(input logic [2:0] code);
        result_t r;
        r = '0;
        r.status = code;
        return r;
    endfunction

    // Result of a finished number.
    function automatic result_t num_result(input parse_state_t s);
        result_t r;
        r.value       = s.negative ? -$signed(s.magnitude) : $signed(s.magnitude);
        r.frac_digits = s.overflowed ? '0 : s.frac_count;
        r.status      = s.overflowed ? ST_OVF : ST_OK;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/adnp_core.sv @@
module adnp_core
    import adnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        is_end,
    input  logic        allow_fraction,
    input  logic        q_room,
    output push_t       push
);

    logic               in_vld_reg, in_vld_next;
    logic [7:0]         ch_reg;
    logic               end_reg;
    parse_state_t       st_reg, st_next;
    logic               adv;
    logic               accept;

    logic               is_dig;
    logic               is_spc;
    logic [3:0]         dval;
    logic [VALUE_W-1:0] lim;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  mag_ext;
    logic               add_ovf;
    logic [VALUE_W-1:0] add_mag;
    logic               add_ovf_flag;

    parse_state_t       tok_st;
    logic               tok_err;
    result_t            r0, r1;
    logic [1:0]         cnt;

    // The input register advances whenever the queue can take two results.
    assign adv      = in_vld_reg && q_room;
    assign in_stall = in_vld_reg && !q_room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (adv)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= CLEAR_STATE;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            st_reg     <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= char_code;
            end_reg <= is_end;
        end
    end

    // Character classes.
    assign is_dig = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_spc = ((ch_reg >= CH_TAB) && (ch_reg <= CH_CR)) || (ch_reg == CH_SPACE);
    assign dval   = 4'(ch_reg - CH_ZERO);

    // One digit step: magnitude times ten plus digit, saturated at the limit.
    assign lim     = st_reg.negative ? {1'b1, {(VALUE_W-1){1'b0}}}
                                     : {1'b0, {(VALUE_W-1){1'b1}}};
    assign mag_ext = {4'b0, st_reg.magnitude};
    assign prod    = (mag_ext << 3) + (mag_ext << 1) + {{(PROD_W-4){1'b0}}, dval};
    assign add_ovf = prod > {4'b0, lim};

    always_comb
    begin
        add_mag      = st_reg.magnitude;
        add_ovf_flag = st_reg.overflowed;
        if (!st_reg.overflowed)
        begin
            if (add_ovf)
            begin
                add_mag      = lim;
                add_ovf_flag = 1'b1;
            end
            else
            begin
                add_mag = prod[VALUE_W-1:0];
            end
        end
    end

    // A character seen as the start of a new token.
    always_comb
    begin
        tok_st  = CLEAR_STATE;
        tok_err = 1'b0;
        if (is_spc)
        begin
            tok_err = 1'b0;
        end
        else if (is_dig)
        begin
            tok_st.phase     = PH_INT;
            tok_st.magnitude = {{(VALUE_W-4){1'b0}}, dval};
        end
        else if ((ch_reg == CH_PLUS) || (ch_reg == CH_MINUS))
        begin
            tok_st.phase    = PH_SIGN;
            tok_st.negative = (ch_reg == CH_MINUS);
        end
        else
        begin
            tok_err = 1'b1;
        end
    end

    // Next parse state and the results of this word.
    always_comb
    begin
        st_next = st_reg;
        r0      = '0;
        r1      = '0;
        cnt     = 2'd0;
        if (adv)
        begin
            if (end_reg)
            begin
                st_next = CLEAR_STATE;
                case (st_reg.phase)
                    PH_SIGN:
                    begin
                        r0  = err_result(ST_SIGN);
                        cnt = 2'd1;
                    end
                    PH_POINT:
                    begin
                        r0  = err_result(ST_POINT);
                        cnt = 2'd1;
                    end
                    PH_INT, PH_FRAC:
                    begin
                        r0  = num_result(st_reg);
                        cnt = 2'd1;
                    end
                    default:
                    begin
                        cnt = 2'd0;
                    end
                endcase
            end
            else
            begin
                case (st_reg.phase)
                    PH_SIGN:
                    begin
                        if (is_dig)
                        begin
                            st_next.phase      = PH_INT;
                            st_next.magnitude  = add_mag;
                            st_next.overflowed = add_ovf_flag;
                        end
                        else
                        begin
                            r0      = err_result(ST_SIGN);
                            cnt     = 2'd1;
                            st_next = CLEAR_STATE;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_dig)
                        begin
                            st_next.magnitude  = add_mag;
                            st_next.overflowed = add_ovf_flag;
                        end
                        else if ((ch_reg == CH_POINT) && allow_fraction)
                        begin
                            st_next.phase = PH_POINT;
                        end
                        else
                        begin
                            r0      = num_result(st_reg);
                            r1      = err_result(ST_INVALID);
                            cnt     = tok_err ? 2'd2 : 2'd1;
                            st_next = tok_st;
                        end
                    end
                    PH_POINT, PH_FRAC:
                    begin
                        if (is_dig)
                        begin
                            st_next.phase = PH_FRAC;
                            if (st_reg.frac_count == FRAC_MAX)
                            begin
                                st_next.overflowed = 1'b1;
                                st_next.magnitude  = lim;
                            end
                            else
                            begin
                                st_next.magnitude  = add_mag;
                                st_next.overflowed = add_ovf_flag;
                                st_next.frac_count = st_reg.frac_count + 1'b1;
                            end
                        end
                        else if (st_reg.phase == PH_POINT)
                        begin
                            r0      = err_result(ST_POINT);
                            cnt     = 2'd1;
                            st_next = CLEAR_STATE;
                        end
                        else
                        begin
                            r0      = num_result(st_reg);
                            r1      = err_result(ST_INVALID);
                            cnt     = tok_err ? 2'd2 : 2'd1;
                            st_next = tok_st;
                        end
                    end
                    default:
                    begin
                        r0      = err_result(ST_INVALID);
                        cnt     = tok_err ? 2'd1 : 2'd0;
                        st_next = tok_st;
                    end
                endcase
            end
            // Mark the final result of the word.
            if (cnt == 2'd2)
                r1.last = 1'b1;
            else
                r0.last = 1'b1;
        end
    end

    assign push.push = adv;
    assign push.cnt  = cnt;
    assign push.r0   = r0;
    assign push.r1   = r1;

endmodule

@@ hw/rtl/adnp_queue.sv @@
module adnp_queue
    import adnp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              room,
    output logic [QCNT_W-1:0] level,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           head
);

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QPTR_W-1:0]   wr_ptr_1;
    logic [QCNT_W-1:0]   n_in;
    logic                pop;

    // Space for two more results, judged on the registered fill level.
    assign room      = cnt_reg <= QCNT_W'(QDEPTH - 2);
    assign level     = cnt_reg;
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign head      = mem[rd_ptr_reg];

    assign wr_ptr_1  = wr_ptr_reg + 1'b1;
    assign n_in      = push.push ? QCNT_W'(push.cnt) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + n_in - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Up to two result words written per cycle at consecutive slots.
    always_ff @(posedge clk)
    begin
        if (push.push && (push.cnt != 2'd0))
            mem[wr_ptr_reg] <= push.r0;
        if (push.push && (push.cnt == 2'd2))
            mem[wr_ptr_1] <= push.r1;
    end

endmodule

@@ hw/rtl/ascii_decimal_number_parser_unit.sv @@
// ASCII decimal number parser.
// Input channel: one character word per cycle (char_code, or is_end to close the
// stream), handshake in_valid / in_stall. Output channel: result words with
// value, frac_digits, status and last, handshake out_valid / out_stall.
// A number equals value divided by ten to the power frac_digits; last marks the
// final result produced by one input word (a word may produce none, one or two).
// Configuration: a write on cfg_valid / cfg_ready (always ready) sets
// allow_fraction; write it only while no word is in flight.
// Path: an accepted word is held in the input register, its results are
// written from there into the result queue, whose head drives the output.
// Throughput: one input word per cycle while in_stall is low; the output side
// delivers one result word per cycle while out_stall is low, set by the single
// read port of the four-entry result queue. When the receiver stalls, results
// collect in the queue; once fewer than two slots remain free the input
// register holds and in_stall rises. Reset clears the parse state to idle,
// empties the queue and clears allow_fraction.
module ascii_decimal_number_parser_unit
    import adnp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    input  logic                      is_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value,
    output logic [FRAC_W-1:0]         frac_digits,
    output logic [2:0]                status,
    output logic                      last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      allow_fraction
);

`include "ascii_decimal_number_parser_unit_assert.svh"

    logic              allow_fraction_reg, allow_fraction_next;
    logic              q_room;
    logic [QCNT_W-1:0] q_level;
    push_t             push;
    result_t           head;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        allow_fraction_next = allow_fraction_reg;
        if (cfg_valid && cfg_ready)
            allow_fraction_next = allow_fraction;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allow_fraction_reg <= 1'b0;
        else
            allow_fraction_reg <= allow_fraction_next;
    end

    // Parse stage.
    adnp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .is_end         (is_end),
        .allow_fraction (allow_fraction_reg),
        .q_room         (q_room),
        .push           (push)
    );

    // Result queue.
    adnp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (q_room),
        .level     (q_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign value       = head.value;
    assign frac_digits = head.frac_digits;
    assign status      = head.status;
    assign last        = head.last;

    // Checks.
    `ADNP_ASSERT_ALWAYS(a_level_bound, q_level <= QCNT_W'(QDEPTH), "result queue overfilled")
    `ADNP_ASSERT_IMPLY(a_status_range, out_valid, status <= ST_OVF, "status code out of range")
    `ADNP_ASSERT_IMPLY(a_err_zero,
        out_valid && (status == ST_SIGN || status == ST_POINT || status == ST_INVALID),
        value == '0 && frac_digits == '0, "error result carries a value")
    `ADNP_ASSERT_IMPLY(a_ovf_frac, out_valid && status == ST_OVF, frac_digits == '0,
        "overflow result carries fraction digits")

endmodule
